>>> hdl/assert_macros.svh
// Assertion macros shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every clock edge outside reset.
`define ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, checked at every clock edge outside reset.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

>>> hdl/tlvsp_pkg.sv
// Shared constants and types for the TLV stream parser.
package tlvsp_pkg;

   // Default width of the byte position and element counters
   localparam int POSITION_BITS_DEFAULT = 24;

   // Width of the offset, index and count fields on the result word
   localparam int FIELD_W = 24;

   // Tag and length byte codes
   localparam logic [4:0] TAG_MULTI_CODE = 5'h1f;
   localparam logic [7:0] LEN_LONG_FLAG  = 8'h80;
   localparam logic [7:0] LEN_LONG_MIN   = 8'h81;
   localparam logic [7:0] LEN_LONG_MAX   = 8'h83;

   // Buffer status codes
   typedef logic [1:0] status_type;
   localparam status_type STATUS_OK        = 2'd0;
   localparam status_type STATUS_BAD_LEN   = 2'd1;
   localparam status_type STATUS_TRUNCATED = 2'd2;

   // Tag byte count codes
   localparam logic [1:0] TAG_BYTES_NONE = 2'd0;
   localparam logic [1:0] TAG_BYTES_ONE  = 2'd1;
   localparam logic [1:0] TAG_BYTES_TWO  = 2'd2;

endpackage

>>> hdl/tlv_stream_parser.sv
// Byte-serial BER-TLV element parser with a single registered result stage.
//
// The parser takes one buffer byte per cycle and returns exactly one result
// word per byte, in the cycle after the byte is accepted.  All decoding of a
// byte is done between the state registers and the result register, so a
// new byte is taken every cycle as long as the result register is empty or
// being drained in the same cycle; only a stalled, full result register
// holds off the request side (req_stall).  A word reports a finished element
// (tag, length, value offset, index) and, on the buffer's last byte, the
// element count and the parse status.  After a bad length byte the rest of
// the buffer is skipped; all state returns to reset after the last byte.
module tlv_stream_parser
   import tlvsp_pkg::*;
#(
   parameter int POSITION_BITS = POSITION_BITS_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   // request channel
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [7:0]           req_data_byte,
   input  logic                 req_last_byte,
   // result channel
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic                 rsp_element_done,
   output logic [15:0]          rsp_tag_value,
   output logic [1:0]           rsp_tag_bytes,
   output logic [FIELD_W-1:0]   rsp_value_length,
   output logic [FIELD_W-1:0]   rsp_value_offset,
   output logic [FIELD_W-1:0]   rsp_element_index,
   output logic                 rsp_buffer_done,
   output logic [FIELD_W-1:0]   rsp_element_count,
   output status_type           rsp_parse_status
);

   // Parser phase codes
   localparam logic [2:0] PH_TAG1  = 3'd0;
   localparam logic [2:0] PH_TAG2  = 3'd1;
   localparam logic [2:0] PH_LEN1  = 3'd2;
   localparam logic [2:0] PH_LENX  = 3'd3;
   localparam logic [2:0] PH_VALUE = 3'd4;
   localparam logic [2:0] PH_HALT  = 3'd5;

   localparam logic [POSITION_BITS-1:0] POS_ONE = POSITION_BITS'(1);

   // Parser state
   logic [2:0]               phase_ff, phase_in;
   logic [15:0]              tag_ff, tag_in;
   logic                     two_tag_ff, two_tag_in;
   logic [1:0]               len_left_ff, len_left_in;
   logic [FIELD_W-1:0]       len_accum_ff, len_accum_in;
   logic [FIELD_W-1:0]       val_left_ff, val_left_in;
   logic [POSITION_BITS-1:0] pos_ff, pos_in;
   logic [POSITION_BITS-1:0] vstart_ff, vstart_in;
   logic [POSITION_BITS-1:0] seen_ff, seen_in;
   status_type               err_ff, err_in;

   // Result register
   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     done_ff;
   logic [15:0]              tagv_ff;
   logic [1:0]               tagb_ff;
   logic [FIELD_W-1:0]       vlen_ff;
   logic [FIELD_W-1:0]       voff_ff;
   logic [FIELD_W-1:0]       vidx_ff;
   logic                     bdone_ff;
   logic [FIELD_W-1:0]       count_ff;
   status_type               status_ff;

   // Per-byte decode results
   logic                     req_accept;
   logic                     elem_done;
   logic [POSITION_BITS-1:0] pos_inc;
   logic [POSITION_BITS-1:0] seen_inc;
   logic [2:0]               phase_step;
   status_type               status_now;
   logic [31:0]              vstart_w, seen_w, seen_inc_w;
   logic [FIELD_W-1:0]       voff_now, vidx_now, count_now;

   assign req_stall  = rsp_valid_ff && rsp_stall;
   assign req_accept = req_valid && !req_stall;

   assign pos_inc  = pos_ff + POS_ONE;
   assign seen_inc = seen_ff + POS_ONE;

   // Phase update for one byte
   always_comb begin
      phase_step   = phase_ff;
      tag_in       = tag_ff;
      two_tag_in   = two_tag_ff;
      len_left_in  = len_left_ff;
      len_accum_in = len_accum_ff;
      val_left_in  = val_left_ff;
      vstart_in    = vstart_ff;
      err_in       = err_ff;
      elem_done    = 1'b0;
      unique case (phase_ff)
         PH_TAG1: begin
            tag_in     = {8'd0, req_data_byte};
            two_tag_in = (req_data_byte[4:0] == TAG_MULTI_CODE);
            phase_step = two_tag_in ? PH_TAG2 : PH_LEN1;
         end
         PH_TAG2: begin
            tag_in     = {tag_ff[7:0], req_data_byte};
            phase_step = PH_LEN1;
         end
         PH_LEN1: begin
            if (req_data_byte < LEN_LONG_FLAG) begin
               // short form: value starts after this byte
               len_accum_in = {16'd0, req_data_byte};
               vstart_in    = pos_inc;
               val_left_in  = len_accum_in;
               if (req_data_byte == 8'd0) begin
                  elem_done  = 1'b1;
                  phase_step = PH_TAG1;
               end else begin
                  phase_step = PH_VALUE;
               end
            end else if (req_data_byte >= LEN_LONG_MIN && req_data_byte <= LEN_LONG_MAX) begin
               len_left_in  = req_data_byte[1:0];
               len_accum_in = '0;
               phase_step   = PH_LENX;
            end else begin
               err_in     = STATUS_BAD_LEN;
               phase_step = PH_HALT;
            end
         end
         PH_LENX: begin
            len_accum_in = {len_accum_ff[FIELD_W-9:0], req_data_byte};
            len_left_in  = len_left_ff - 2'd1;
            if (len_left_in == 2'd0) begin
               vstart_in   = pos_inc;
               val_left_in = len_accum_in;
               if (len_accum_in == '0) begin
                  elem_done  = 1'b1;
                  phase_step = PH_TAG1;
               end else begin
                  phase_step = PH_VALUE;
               end
            end
         end
         PH_VALUE: begin
            val_left_in = val_left_ff - FIELD_W'(1);
            if (val_left_in == '0) begin
               elem_done  = 1'b1;
               phase_step = PH_TAG1;
            end
         end
         default: begin
            // halted after an error, or a phase code with no meaning
         end
      endcase
   end

   // Buffer status on the last byte: a length error, earlier or on this byte, wins over truncation
   always_comb begin
      priority if (err_in != STATUS_OK) begin
         status_now = err_in;
      end else if (phase_step != PH_TAG1) begin
         status_now = STATUS_TRUNCATED;
      end else begin
         status_now = STATUS_OK;
      end
   end

   assign seen_in = elem_done ? seen_inc : seen_ff;
   assign pos_in  = pos_inc;
   assign phase_in = phase_step;

   // Fit position counters to the result field width
   assign vstart_w   = 32'(vstart_in);
   assign seen_w     = 32'(seen_ff);
   assign seen_inc_w = 32'(seen_in);
   assign voff_now   = vstart_w[FIELD_W-1:0];
   assign vidx_now   = seen_w[FIELD_W-1:0];
   assign count_now  = seen_inc_w[FIELD_W-1:0];

   // State registers; the last byte returns everything to reset
   always_ff @(posedge clock) begin
      if (reset || (req_accept && req_last_byte)) begin
         phase_ff     <= PH_TAG1;
         tag_ff       <= '0;
         two_tag_ff   <= 1'b0;
         len_left_ff  <= '0;
         len_accum_ff <= '0;
         val_left_ff  <= '0;
         pos_ff       <= '0;
         vstart_ff    <= '0;
         seen_ff      <= '0;
         err_ff       <= STATUS_OK;
      end else if (req_accept) begin
         phase_ff     <= phase_in;
         tag_ff       <= tag_in;
         two_tag_ff   <= two_tag_in;
         len_left_ff  <= len_left_in;
         len_accum_ff <= len_accum_in;
         val_left_ff  <= val_left_in;
         pos_ff       <= pos_in;
         vstart_ff    <= vstart_in;
         seen_ff      <= seen_in;
         err_ff       <= err_in;
      end
   end

   // Result word valid
   always_comb begin
      priority if (req_accept) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Result word payload; fields are zero when not reported
   always_ff @(posedge clock) begin
      if (req_accept) begin
         done_ff   <= elem_done;
         tagv_ff   <= elem_done ? tag_in : 16'd0;
         tagb_ff   <= !elem_done ? TAG_BYTES_NONE
                    : (two_tag_in ? TAG_BYTES_TWO : TAG_BYTES_ONE);
         vlen_ff   <= elem_done ? len_accum_in : '0;
         voff_ff   <= elem_done ? voff_now : '0;
         vidx_ff   <= elem_done ? vidx_now : '0;
         bdone_ff  <= req_last_byte;
         count_ff  <= (req_last_byte && status_now == STATUS_OK) ? count_now : '0;
         status_ff <= req_last_byte ? status_now : STATUS_OK;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_element_done  = done_ff;
   assign rsp_tag_value     = tagv_ff;
   assign rsp_tag_bytes     = tagb_ff;
   assign rsp_value_length  = vlen_ff;
   assign rsp_value_offset  = voff_ff;
   assign rsp_element_index = vidx_ff;
   assign rsp_buffer_done   = bdone_ff;
   assign rsp_element_count = count_ff;
   assign rsp_parse_status  = status_ff;

endmodule

>>> hdl/tlvsp_checker.sv
// Port-level checker for the TLV stream parser, bound into every tlv_stream_parser instance.
`include "assert_macros.svh"

module tlvsp_checker
   import tlvsp_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_stall,
   input logic [7:0]         req_data_byte,
   input logic               req_last_byte,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic               rsp_element_done,
   input logic [15:0]        rsp_tag_value,
   input logic [1:0]         rsp_tag_bytes,
   input logic [FIELD_W-1:0] rsp_value_length,
   input logic [FIELD_W-1:0] rsp_value_offset,
   input logic [FIELD_W-1:0] rsp_element_index,
   input logic               rsp_buffer_done,
   input logic [FIELD_W-1:0] rsp_element_count,
   input status_type         rsp_parse_status
);

   logic byte_taken;
   logic mid_buffer;
   logic failed_buffer;
   logic tag_fields_ok;

   assign byte_taken    = req_valid && !req_stall;
   assign mid_buffer    = rsp_valid && !rsp_buffer_done;
   assign failed_buffer = rsp_valid && rsp_parse_status != STATUS_OK;

   // a finished element carries a one- or two-byte tag, otherwise no tag
   assign tag_fields_ok = rsp_element_done
                        ? (rsp_tag_bytes == TAG_BYTES_ONE || rsp_tag_bytes == TAG_BYTES_TWO)
                        : (rsp_tag_bytes == TAG_BYTES_NONE && rsp_value_length == '0);

   // every accepted byte yields a result word in the next cycle
   `ASSERT_NEXT(a_word_follows, clock, reset, byte_taken, rsp_valid)

   // status is only reported with the last byte
   `ASSERT_SAME(a_status_at_end, clock, reset, mid_buffer, rsp_parse_status == STATUS_OK)

   // a failed buffer reports no element count
   `ASSERT_SAME(a_count_on_ok, clock, reset, failed_buffer, rsp_element_count == '0)

   // tag byte count matches element_done; without an element the length is zero too
   `ASSERT_SAME(a_tag_bytes, clock, reset, rsp_valid, tag_fields_ok)

endmodule

bind tlv_stream_parser tlvsp_checker u_tlvsp_checker (.*);

>>> bench/tlv_stream_parser_tb.sv
// Self-checking testbench for the BER-TLV stream parser: random bursts, stalls, golden decoder.
module tlv_stream_parser_tb;
   import tlvsp_pkg::*;

   localparam int POS_W        = POSITION_BITS_DEFAULT;
   localparam int TARGET_BYTES = 1750;
   localparam int IDLE_LIMIT   = 3000;
   localparam int DRAIN_CYCLES = 16;
   localparam int HOLD_CYCLES  = 250;

   // decoder phases
   typedef enum logic [2:0] {
      SEEK_TAG, TAG_SECOND, LEN_FIRST, LEN_MORE, IN_VALUE, SKIP_REST
   } parse_phase_type;

   typedef struct packed {
      logic [7:0] data;
      logic       last_flag;
   } tlv_byte_type;

   typedef struct packed {
      logic               element_done;
      logic [15:0]        tag_value;
      logic [1:0]         tag_bytes;
      logic [FIELD_W-1:0] value_length;
      logic [FIELD_W-1:0] value_offset;
      logic [FIELD_W-1:0] element_index;
      logic               buffer_done;
      logic [FIELD_W-1:0] element_count;
      status_type         parse_status;
   } parse_word_type;

   logic               clock;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [7:0]         req_data_byte = 8'h00;
   logic               req_last_byte = 1'b0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic               rsp_element_done;
   logic [15:0]        rsp_tag_value;
   logic [1:0]         rsp_tag_bytes;
   logic [FIELD_W-1:0] rsp_value_length;
   logic [FIELD_W-1:0] rsp_value_offset;
   logic [FIELD_W-1:0] rsp_element_index;
   logic               rsp_buffer_done;
   logic [FIELD_W-1:0] rsp_element_count;
   status_type         rsp_parse_status;

   tlv_byte_type   byte_q[$];      // bytes still to be offered
   parse_word_type word_q[$];      // decoded words still to arrive
   logic [7:0]     build_q[$];     // buffer under construction
   int             fail_count = 0;
   int             words_seen = 0;
   int             hold_left = 0;

   // golden decoder state
   parse_phase_type    cur_phase = SEEK_TAG;
   logic [15:0]        tag_acc = '0;
   logic               tag_is_two = 1'b0;
   logic [1:0]         len_bytes_left = '0;
   logic [FIELD_W-1:0] len_acc = '0;
   logic [FIELD_W-1:0] val_bytes_left = '0;
   logic [POS_W-1:0]   byte_pos = '0;
   logic [POS_W-1:0]   val_start = '0;
   logic [POS_W-1:0]   elem_count = '0;
   status_type         err_code = STATUS_OK;

   tlv_stream_parser dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data_byte    (req_data_byte),
      .req_last_byte    (req_last_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_element_done (rsp_element_done),
      .rsp_tag_value    (rsp_tag_value),
      .rsp_tag_bytes    (rsp_tag_bytes),
      .rsp_value_length (rsp_value_length),
      .rsp_value_offset (rsp_value_offset),
      .rsp_element_index(rsp_element_index),
      .rsp_buffer_done  (rsp_buffer_done),
      .rsp_element_count(rsp_element_count),
      .rsp_parse_status (rsp_parse_status)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Decode one accepted byte and return the word it should produce
   function automatic parse_word_type decode_byte(input logic [7:0] b, input logic last_flag);
      parse_word_type     w;
      logic [POS_W-1:0]   pos;
      logic               len_ready;
      logic               done;
      logic [FIELD_W-1:0] new_len;
      status_type         st;
      w = '0;
      pos = byte_pos;
      len_ready = 1'b0;
      done = 1'b0;
      new_len = '0;
      case (cur_phase)
         SEEK_TAG: begin
            tag_acc = {8'h00, b};
            tag_is_two = (b[4:0] == TAG_MULTI_CODE);
            cur_phase = tag_is_two ? TAG_SECOND : LEN_FIRST;
         end
         TAG_SECOND: begin
            tag_acc = {tag_acc[7:0], b};
            cur_phase = LEN_FIRST;
         end
         LEN_FIRST: begin
            if (b < LEN_LONG_FLAG) begin
               len_ready = 1'b1;
               new_len[7:0] = b;
            end else if (b >= LEN_LONG_MIN && b <= LEN_LONG_MAX) begin
               len_bytes_left = b[1:0];
               len_acc = '0;
               cur_phase = LEN_MORE;
            end else begin
               err_code = STATUS_BAD_LEN;
               cur_phase = SKIP_REST;
            end
         end
         LEN_MORE: begin
            len_acc = (len_acc << 8) | b;
            len_bytes_left = len_bytes_left - 2'd1;
            if (len_bytes_left == 2'd0) begin
               len_ready = 1'b1;
               new_len = len_acc;
            end
         end
         IN_VALUE: begin
            val_bytes_left = val_bytes_left - 1'b1;
            if (val_bytes_left == '0) done = 1'b1;
         end
         default: ;
      endcase

      // length complete: zero length finishes the element at once
      if (len_ready) begin
         len_acc = new_len;
         val_start = pos + 1'b1;
         if (new_len == '0) begin
            done = 1'b1;
         end else begin
            val_bytes_left = new_len;
            cur_phase = IN_VALUE;
         end
      end

      if (done) begin
         w.element_done  = 1'b1;
         w.tag_value     = tag_acc;
         w.tag_bytes     = tag_is_two ? TAG_BYTES_TWO : TAG_BYTES_ONE;
         w.value_length  = len_acc;
         w.value_offset  = val_start;
         w.element_index = elem_count;
         elem_count = elem_count + 1'b1;
         cur_phase = SEEK_TAG;
      end
      byte_pos = pos + 1'b1;

      // end of buffer: report status, then back to reset state
      if (last_flag) begin
         if (err_code != STATUS_OK) st = err_code;
         else if (cur_phase != SEEK_TAG) st = STATUS_TRUNCATED;
         else st = STATUS_OK;
         w.buffer_done   = 1'b1;
         w.parse_status  = st;
         w.element_count = (st == STATUS_OK) ? elem_count : '0;
         cur_phase      = SEEK_TAG;
         tag_acc        = '0;
         tag_is_two     = 1'b0;
         len_bytes_left = '0;
         len_acc        = '0;
         val_bytes_left = '0;
         byte_pos       = '0;
         val_start      = '0;
         elem_count     = '0;
         err_code       = STATUS_OK;
      end
      return w;
   endfunction

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         fail_count++;
      end
   endtask

   // Move the buffer under construction into the byte queue, last byte marked
   task automatic flush_buffer();
      tlv_byte_type t;
      for (int i = 0; i < build_q.size(); i++) begin
         t.data = build_q[i];
         t.last_flag = (i == build_q.size() - 1);
         byte_q.push_back(t);
      end
      build_q.delete();
   endtask

   // Append one well-formed element with random tag, length form and value
   task automatic add_element();
      logic [7:0]  b1;
      logic [23:0] vlen;
      int          need;
      int          nbytes;
      int          r;
      b1 = 8'($urandom);
      if ($urandom_range(0, 2) == 0) begin
         b1[4:0] = TAG_MULTI_CODE;
         build_q.push_back(b1);
         build_q.push_back(8'($urandom));
      end else begin
         if (b1[4:0] == TAG_MULTI_CODE) b1[0] = 1'b0;
         build_q.push_back(b1);
      end
      r = $urandom_range(0, 19);
      if (r < 12) vlen = 24'($urandom_range(0, 8));
      else if (r < 19) vlen = 24'($urandom_range(0, 40));
      else vlen = 24'($urandom_range(128, 300));
      if (vlen < 24'd128 && $urandom_range(0, 2) != 0) begin
         build_q.push_back(vlen[7:0]);
      end else begin
         need = (vlen > 24'd255) ? 2 : 1;
         nbytes = $urandom_range(need, 3);
         build_q.push_back(LEN_LONG_FLAG | 8'(nbytes));
         for (int i = nbytes - 1; i >= 0; i--) build_q.push_back(vlen[8*i +: 8]);
      end
      for (int i = 0; i < vlen; i++) build_q.push_back(8'($urandom));
   endtask

   // Driver: bursts of bytes with random gaps; no gaps while the receiver holds off
   int burst_left = 0;
   int gap_left = 0;
   always @(posedge clock) begin : drive_bytes
      tlv_byte_type item;
      if (reset) begin
         req_valid <= 1'b0;
         burst_left <= 0;
         gap_left <= 0;
      end else if (!(req_valid && req_stall)) begin
         if (gap_left > 0 && hold_left == 0) begin
            req_valid <= 1'b0;
            gap_left <= gap_left - 1;
         end else if (byte_q.size() != 0) begin
            item = byte_q.pop_front();
            req_valid <= 1'b1;
            req_data_byte <= item.data;
            req_last_byte <= item.last_flag;
            if (burst_left <= 1) begin
               burst_left <= $urandom_range(1, 40);
               gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            end else begin
               burst_left <= burst_left - 1;
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Receiver stall pattern, with long hold-offs to back up the parser
   int stall_mode = 0;
   int mode_left = 0;
   int pattern_cnt = 0;
   int hold_mark = 300;
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (words_seen >= hold_mark) begin
         rsp_stall <= 1'b1;
         hold_left <= HOLD_CYCLES;
         hold_mark <= hold_mark + 800;
      end else begin
         pattern_cnt <= pattern_cnt + 1;
         if (mode_left == 0) begin
            stall_mode <= $urandom_range(0, 3);
            mode_left <= $urandom_range(20, 200);
         end else begin
            mode_left <= mode_left - 1;
         end
         case (stall_mode)
            0:       rsp_stall <= 1'b0;
            1:       rsp_stall <= ($urandom_range(0, 3) == 0);
            2:       rsp_stall <= ($urandom_range(0, 3) != 0);
            default: rsp_stall <= ((pattern_cnt % 5) < 2);
         endcase
      end
   end

   // Monitor: decode accepted bytes, compare accepted words in order
   always @(posedge clock) begin : watch_words
      parse_word_type want;
      if (!reset) begin
         if (req_valid && !req_stall)
            word_q.push_back(decode_byte(req_data_byte, req_last_byte));
         if (rsp_valid && !rsp_stall) begin
            words_seen <= words_seen + 1;
            if (word_q.size() == 0) begin
               $display("%0t: result word with none expected", $time);
               fail_count++;
            end else begin
               want = word_q.pop_front();
               check_field("element_done", want.element_done, rsp_element_done);
               check_field("tag_value", want.tag_value, rsp_tag_value);
               check_field("tag_bytes", want.tag_bytes, rsp_tag_bytes);
               check_field("value_length", want.value_length, rsp_value_length);
               check_field("value_offset", want.value_offset, rsp_value_offset);
               check_field("element_index", want.element_index, rsp_element_index);
               check_field("buffer_done", want.buffer_done, rsp_buffer_done);
               check_field("element_count", want.element_count, rsp_element_count);
               check_field("parse_status", want.parse_status, rsp_parse_status);
            end
         end
      end
   end

   // Watchdog: end the run when neither channel moves for too long
   int idle_cycles = 0;
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Stimulus, reset and end of run
   initial begin
      int kind;
      int n;
      int cut;

      // truncated after a one-byte tag
      build_q = {8'h5A};
      flush_buffer();
      // two-byte tag, zero length completing on the last byte
      build_q = {8'h9F, 8'h1A, 8'h00};
      flush_buffer();
      // element with one length byte, then bad length 0x80, then ignored byte
      build_q = {8'h01, 8'h81, 8'h02, 8'hAA, 8'hBB, 8'h03, 8'h80, 8'h11};
      flush_buffer();
      // all-ones tag, three zero length bytes ending the buffer
      build_q = {8'hFF, 8'hFF, 8'h83, 8'h00, 8'h00, 8'h00};
      flush_buffer();
      // truncated inside the long length
      build_q = {8'h3F, 8'hE0, 8'h82, 8'h01};
      flush_buffer();
      // bad length 0x84 on the last byte
      build_q = {8'h04, 8'h84};
      flush_buffer();
      // truncated inside the value
      build_q = {8'h00, 8'h7F, 8'h12};
      flush_buffer();

      // random buffers: mostly well formed, some broken or pure noise
      while (byte_q.size() < TARGET_BYTES) begin
         kind = $urandom_range(0, 11);
         n = $urandom_range(1, 4);
         if (kind == 3) begin
            n = $urandom_range(1, 12);
            for (int i = 0; i < n; i++) build_q.push_back(8'($urandom));
         end else begin
            for (int i = 0; i < n; i++) add_element();
            if (kind == 2) begin
               // bad length form followed by junk
               build_q.push_back(8'($urandom_range(0, 30)));
               build_q.push_back(($urandom_range(0, 2) == 0) ? LEN_LONG_FLAG
                                 : 8'($urandom_range(8'h84, 8'hFF)));
               n = $urandom_range(0, 4);
               for (int i = 0; i < n; i++) build_q.push_back(8'($urandom));
            end else if (kind == 4) begin
               // huge three-byte length, buffer ends early in the value
               build_q.push_back(8'h5E);
               build_q.push_back(LEN_LONG_MAX);
               for (int i = 0; i < 3; i++) build_q.push_back(8'($urandom));
               n = $urandom_range(0, 3);
               for (int i = 0; i < n; i++) build_q.push_back(8'($urandom));
            end else if (kind <= 1 && build_q.size() > 1) begin
               cut = $urandom_range(1, build_q.size() - 1);
               build_q = build_q[0:cut-1];
            end
         end
         flush_buffer();
      end

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      do @(negedge clock);
      while (byte_q.size() != 0 || req_valid || word_q.size() != 0);
      repeat (DRAIN_CYCLES) @(negedge clock);

      if (fail_count == 0 && word_q.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
